// ===== rtl/cbm_pkg.sv =====
// Shared types, constants and the controller-kind decode for the cartridge bank mapper.
package cbm_pkg;

	localparam int ROM_ADDR_BITS_DEF = 23;
	localparam int RAM_ADDR_BITS_DEF = 17;
	localparam int MEM_ADDR_W        = 23;
	localparam int PADDR_W           = 3;
	localparam int PDATA_W           = 32;

	localparam logic REG_CART_TYPE = 1'b0;
	localparam logic REG_RAM_SIZE  = 1'b1;

	localparam logic [7:0] RAM_SIZE_8K   = 8'd2;
	localparam logic [7:0] RAM_SIZE_32K  = 8'd3;
	localparam logic [7:0] RAM_SIZE_128K = 8'd4;
	localparam logic [3:0] RAM_EN_KEY    = 4'hA;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		KIND_ROM,
		KIND_MBC1,
		KIND_MBC2,
		KIND_MBC3,
		KIND_MBC5,
		KIND_BAD
	} kind_t;

	typedef enum logic [2:0] {
		TGT_NONE   = 3'd0,
		TGT_ROM    = 3'd1,
		TGT_RAM_RD = 3'd2,
		TGT_RAM_WR = 3'd3,
		TGT_BAD    = 3'd4
	} tgt_t;

	typedef struct packed {
		logic       ram_enabled;
		logic [8:0] rom_bank_number;
		logic [3:0] ram_bank_number;
	} bank_state_t;

	typedef struct packed {
		tgt_t                  target;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic [7:0]            ram_write_data;
		logic                  force_high_nibble;
	} map_res_t;

	function automatic kind_t kind_of(input logic [7:0] t);
		kind_t k;
		unique case (t) inside
			8'h00:          k = KIND_ROM;
			[8'h01:8'h03]:  k = KIND_MBC1;
			8'h05, 8'h06:   k = KIND_MBC2;
			[8'h10:8'h13]:  k = KIND_MBC3;
			[8'h19:8'h1E]:  k = KIND_MBC5;
			default:        k = KIND_BAD;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/cbm_map.sv =====
// Address decode, bank translation and bank register update for one bus request.
module cbm_map import cbm_pkg::*; #(
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
	parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
	input  logic        opcode,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_value,
	input  logic [7:0]  cart_type,
	input  logic [7:0]  ram_size_code,
	input  bank_state_t cur,
	output bank_state_t nxt,
	output map_res_t    res
);

	localparam logic [MEM_ADDR_W-1:0] ROM_MASK =
		MEM_ADDR_W'((24'(1) << ROM_ADDR_BITS) - 24'(1));
	localparam logic [16:0] RAM_MASK = 17'((18'(1) << RAM_ADDR_BITS) - 18'(1));

	kind_t       kind;
	logic        in_ram;
	logic        ram_ok;
	logic [16:0] ram_byte_addr;
	logic [7:0]  bank_lo;
	logic [8:0]  rom_sel;
	logic [MEM_ADDR_W-1:0] rom_lo_addr;
	logic [MEM_ADDR_W-1:0] rom_hi_addr;

	always_comb begin
		kind   = kind_of(cart_type);
		in_ram = (bus_address[15:13] == 3'b101);
		ram_ok = cur.ram_enabled &&
			((kind == KIND_MBC2) || (ram_size_code == RAM_SIZE_8K) ||
			 (ram_size_code == RAM_SIZE_32K) ||
			 ((ram_size_code == RAM_SIZE_128K) && (kind == KIND_MBC5)));
		if (kind == KIND_MBC2) begin
			ram_byte_addr = {8'd0, bus_address[8:0]} & RAM_MASK;
		end else if (ram_size_code == RAM_SIZE_8K) begin
			ram_byte_addr = {4'd0, bus_address[12:0]} & RAM_MASK;
		end else begin
			ram_byte_addr = {cur.ram_bank_number, bus_address[12:0]} & RAM_MASK;
		end

		bank_lo = cur.rom_bank_number[7:0];
		if (kind == KIND_MBC5) begin
			rom_sel = cur.rom_bank_number;
		end else if (bank_lo == 8'd0) begin
			rom_sel = 9'd1;
		end else begin
			rom_sel = {1'b0, bank_lo};
		end
		rom_lo_addr = MEM_ADDR_W'(bus_address) & ROM_MASK;
		rom_hi_addr = {rom_sel, bus_address[13:0]} & ROM_MASK;
	end

	always_comb begin
		nxt = cur;
		res = '{target: TGT_NONE, mem_address: '0, ram_write_data: 8'd0,
			force_high_nibble: 1'b0};
		if (kind == KIND_BAD) begin
			res.target = TGT_BAD;
		end else if (kind == KIND_ROM) begin
			if (opcode == OP_READ) begin
				res.target      = TGT_ROM;
				res.mem_address = rom_lo_addr;
			end
		end else if (opcode == OP_READ) begin
			if (bus_address[15:14] == 2'b00) begin
				res.target      = TGT_ROM;
				res.mem_address = rom_lo_addr;
			end else if (bus_address[15:14] == 2'b01) begin
				res.target      = TGT_ROM;
				res.mem_address = rom_hi_addr;
			end else if (in_ram && ram_ok) begin
				res.target            = TGT_RAM_RD;
				res.mem_address       = MEM_ADDR_W'(ram_byte_addr);
				res.force_high_nibble = (kind == KIND_MBC2);
			end
		end else if (kind == KIND_MBC2) begin
			if (bus_address[15:14] == 2'b00) begin
				if (bus_address[8]) begin
					nxt.rom_bank_number = {5'd0, write_value[3:0]};
				end else begin
					nxt.ram_enabled = (write_value[3:0] == RAM_EN_KEY);
				end
			end else if (in_ram && ram_ok) begin
				res.target         = TGT_RAM_WR;
				res.mem_address    = MEM_ADDR_W'(ram_byte_addr);
				res.ram_write_data = write_value;
			end
		end else begin
			case (bus_address[15:13])
				3'd0: nxt.ram_enabled = (write_value[3:0] == RAM_EN_KEY);
				3'd1: begin
					if (kind == KIND_MBC1) begin
						nxt.rom_bank_number = {4'd0, write_value[4:0]};
					end else if (kind == KIND_MBC3) begin
						nxt.rom_bank_number = {2'd0, write_value[6:0]};
					end else if (!bus_address[12]) begin
						nxt.rom_bank_number = {cur.rom_bank_number[8], write_value};
					end else begin
						nxt.rom_bank_number = {write_value[0], cur.rom_bank_number[7:0]};
					end
				end
				3'd2: begin
					if (kind == KIND_MBC5) begin
						nxt.ram_bank_number = write_value[3:0];
					end else begin
						nxt.ram_bank_number = {2'd0, write_value[1:0]};
					end
				end
				3'd3: ;
				default: begin
					if (in_ram && ram_ok) begin
						res.target         = TGT_RAM_WR;
						res.mem_address    = MEM_ADDR_W'(ram_byte_addr);
						res.ram_write_data = write_value;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: request register, bank state, result register.
// Usage:
//  - Requests (opcode, bus_address, write_value) enter on in_valid/in_stall; a
//    request is taken at a clock edge with in_valid high and in_stall low.
//  - Each request gives exactly one result (target, mem_address,
//    ram_write_data, force_high_nibble) on out_valid/out_stall, in order.
//  - The request is registered, then decoded against the bank registers
//    and written to the result register.
//  - Throughput is one request per cycle while out_stall is low; the decode is a
//    single pass of compares and bit concatenation between the two registers.
//  - When out_stall holds a result, the request register still takes one
//    more request; in_stall rises only when both registers are full.
//  - cart_type and ram_size_code must be written over the APB port only while no request is
//    in flight; the block does not enforce it. pready is always high, reads return the value.
//  - Reset clears the configuration, the RAM enable and both bank numbers,
//    and empties both registers.
module cartridge_bank_mapper import cbm_pkg::*; #(
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
	parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            write_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            target,
	output logic [MEM_ADDR_W-1:0] mem_address,
	output logic [7:0]            ram_write_data,
	output logic                  force_high_nibble
);

	logic [7:0]  cart_type_q;
	logic [7:0]  ram_size_code_q;
	logic        cfg_wr;

	logic        valid_s1;
	logic        opcode_s1;
	logic [15:0] bus_address_s1;
	logic [7:0]  write_value_s1;

	bank_state_t bank_q;
	bank_state_t bank_nxt;
	map_res_t    map_res;

	logic        out_valid_q;
	map_res_t    res_q;

	logic        out_free;
	logic        advance;
	logic        accept;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		case (paddr[2])
			REG_CART_TYPE: prdata = {24'd0, cart_type_q};
			REG_RAM_SIZE:  prdata = {24'd0, ram_size_code_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q     <= 8'd0;
			ram_size_code_q <= 8'd0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CART_TYPE) begin
				cart_type_q <= pwdata[7:0];
			end else begin
				ram_size_code_q <= pwdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1      <= opcode;
			bus_address_s1 <= bus_address;
			write_value_s1 <= write_value;
		end
	end

	cbm_map #(
		.ROM_ADDR_BITS (ROM_ADDR_BITS),
		.RAM_ADDR_BITS (RAM_ADDR_BITS)
	) u_map (
		.opcode        (opcode_s1),
		.bus_address   (bus_address_s1),
		.write_value   (write_value_s1),
		.cart_type     (cart_type_q),
		.ram_size_code (ram_size_code_q),
		.cur           (bank_q),
		.nxt           (bank_nxt),
		.res           (map_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
		end else if (advance) begin
			bank_q <= bank_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= map_res;
		end
	end

	assign out_valid         = out_valid_q;
	assign target            = res_q.target;
	assign mem_address       = res_q.mem_address;
	assign ram_write_data    = res_q.ram_write_data;
	assign force_high_nibble = res_q.force_high_nibble;

`ifndef SYNTHESIS
	a_bank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(bank_q))
		else $error("bank registers changed without a request moving");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("request stalled with a free register");

	a_nibble_ram: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.force_high_nibble) |-> (res_q.target == TGT_RAM_RD))
		else $error("high nibble forced on a non RAM read");

	a_wdata_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.target != TGT_RAM_WR)) |-> (res_q.ram_write_data == 8'd0))
		else $error("write data on a result that is not a RAM write");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ((res_q.target == TGT_NONE) || (res_q.target == TGT_BAD)))
			|-> (res_q.mem_address == '0))
		else $error("address given with no memory selected");
`endif

endmodule

// ===== dv/tb_cartridge_bank_mapper.sv =====
// Self-checking testbench for the cartridge bank mapper: directed and random bus requests against a model.
module tb_cartridge_bank_mapper;
	import cbm_pkg::*;

	localparam logic [MEM_ADDR_W-1:0] ROM_MASK = MEM_ADDR_W'((64'd1 << ROM_ADDR_BITS_DEF) - 1);
	localparam logic [MEM_ADDR_W-1:0] RAM_MASK = MEM_ADDR_W'((64'd1 << RAM_ADDR_BITS_DEF) - 1);
	localparam int LONG_HOLD = 80;

	class bank_map_checker;
		logic [7:0]     cart_type;
		logic [7:0]     size_code;
		logic           ram_en;
		logic [8:0]     rom_sel;
		logic [3:0]     ram_sel;
		map_res_t       pending_maps[$];
		int             errors;

		function new();
			cart_type = '0;
			size_code = '0;
			ram_en    = 1'b0;
			rom_sel   = '0;
			ram_sel   = '0;
			errors    = 0;
		endfunction

		function void set_reg(logic idx, logic [7:0] v);
			if (idx == REG_CART_TYPE)
				cart_type = v;
			else
				size_code = v;
		endfunction

		function kind_t decode_kind();
			if (cart_type == 8'h00) return KIND_ROM;
			if (cart_type >= 8'h01 && cart_type <= 8'h03) return KIND_MBC1;
			if (cart_type == 8'h05 || cart_type == 8'h06) return KIND_MBC2;
			if (cart_type >= 8'h10 && cart_type <= 8'h13) return KIND_MBC3;
			if (cart_type >= 8'h19 && cart_type <= 8'h1E) return KIND_MBC5;
			return KIND_BAD;
		endfunction

		// external RAM window: enabled, and banked or unbanked per size code
		function bit ram_hit(kind_t k, logic [15:0] a, output logic [MEM_ADDR_W-1:0] ra);
			logic [MEM_ADDR_W-1:0] off;
			ra = '0;
			off = MEM_ADDR_W'(a[12:0]);
			if (a < 16'hA000 || a > 16'hBFFF || !ram_en) return 1'b0;
			if (k == KIND_MBC2)
				ra = off & 23'h1FF;
			else if (size_code == RAM_SIZE_8K)
				ra = off;
			else if (size_code == RAM_SIZE_32K || (size_code == RAM_SIZE_128K && k == KIND_MBC5))
				ra = (MEM_ADDR_W'(ram_sel) << 13) + off;
			else
				return 1'b0;
			ra = ra & RAM_MASK;
			return 1'b1;
		endfunction

		function void note_request(logic op, logic [15:0] a, logic [7:0] d);
			map_res_t r;
			kind_t k;
			logic [8:0] bank;
			logic [MEM_ADDR_W-1:0] ra;
			r = '0;
			r.target = TGT_NONE;
			k = decode_kind();
			if (k == KIND_BAD) begin
				r.target = TGT_BAD;
			end else if (k == KIND_ROM) begin
				if (op == OP_READ) begin
					r.target = TGT_ROM;
					r.mem_address = MEM_ADDR_W'(a) & ROM_MASK;
				end
			end else if (op == OP_READ) begin
				if (a < 16'h4000) begin
					r.target = TGT_ROM;
					r.mem_address = MEM_ADDR_W'(a) & ROM_MASK;
				end else if (a < 16'h8000) begin
					bank = rom_sel;
					if (k != KIND_MBC5) begin
						bank[8] = 1'b0;
						if (bank == '0) bank = 9'd1;
					end
					r.target = TGT_ROM;
					r.mem_address = {bank, a[13:0]} & ROM_MASK;
				end else if (ram_hit(k, a, ra)) begin
					r.target = TGT_RAM_RD;
					r.mem_address = ra;
					r.force_high_nibble = (k == KIND_MBC2);
				end
			end else if (k == KIND_MBC2) begin
				if (a < 16'h4000) begin
					if (a[8])
						rom_sel = {5'b0, d[3:0]};
					else
						ram_en = (d[3:0] == RAM_EN_KEY);
				end else if (ram_hit(k, a, ra)) begin
					r.target = TGT_RAM_WR;
					r.mem_address = ra;
					r.ram_write_data = d;
				end
			end else begin
				if (a < 16'h2000) begin
					ram_en = (d[3:0] == RAM_EN_KEY);
				end else if (a < 16'h4000) begin
					if (k == KIND_MBC1)
						rom_sel = {4'b0, d[4:0]};
					else if (k == KIND_MBC3)
						rom_sel = {2'b0, d[6:0]};
					else if (a < 16'h3000)
						rom_sel[7:0] = d;
					else
						rom_sel[8] = d[0];
				end else if (a < 16'h6000) begin
					ram_sel = (k == KIND_MBC5) ? d[3:0] : {2'b0, d[1:0]};
				end else if (a < 16'h8000) begin
					// bank mode select, ignored
				end else if (ram_hit(k, a, ra)) begin
					r.target = TGT_RAM_WR;
					r.mem_address = ra;
					r.ram_write_data = d;
				end
			end
			pending_maps.push_back(r);
		endfunction

		function void check_result(logic [2:0] t, logic [MEM_ADDR_W-1:0] ma, logic [7:0] wd,
				logic hi);
			map_res_t e;
			if (pending_maps.size() == 0) begin
				$error("result with no request outstanding: target %0d addr 0x%06h", t, ma);
				errors++;
				return;
			end
			e = pending_maps.pop_front();
			if (t !== e.target) begin
				$error("target: expected %0d, got %0d", e.target, t);
				errors++;
			end
			if (ma !== e.mem_address) begin
				$error("mem_address: expected 0x%06h, got 0x%06h", e.mem_address, ma);
				errors++;
			end
			if (wd !== e.ram_write_data) begin
				$error("ram_write_data: expected 0x%02h, got 0x%02h", e.ram_write_data, wd);
				errors++;
			end
			if (hi !== e.force_high_nibble) begin
				$error("force_high_nibble: expected %0d, got %0d", e.force_high_nibble, hi);
				errors++;
			end
		endfunction

		function int pending();
			return pending_maps.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  opcode;
	logic [15:0]           bus_address;
	logic [7:0]            write_value;
	logic                  out_valid;
	logic                  out_stall;
	logic [2:0]            target;
	logic [MEM_ADDR_W-1:0] mem_address;
	logic [7:0]            ram_write_data;
	logic                  force_high_nibble;

	bank_map_checker sb = new();
	bit burst;
	bit hold_next;

	cartridge_bank_mapper u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.opcode            (opcode),
		.bus_address       (bus_address),
		.write_value       (write_value),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.target            (target),
		.mem_address       (mem_address),
		.ram_write_data    (ram_write_data),
		.force_high_nibble (force_high_nibble)
	);

	always #2 clk = ~clk;

	task automatic write_reg(logic idx, logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.set_reg(idx, v);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		if (prdata !== {24'b0, v}) begin
			$error("prdata: expected 0x%08h, got 0x%08h", {24'b0, v}, prdata);
			sb.errors++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(logic [7:0] ctype, logic [7:0] rsize);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_CART_TYPE, ctype);
		write_reg(REG_RAM_SIZE, rsize);
	endtask

	task automatic send(logic op, logic [15:0] a, logic [7:0] d);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		bus_address <= a;
		write_value <= d;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sb.note_request(op, a, d);
	endtask

	// mostly control writes and accesses inside the mapped windows, some noise
	task automatic send_random();
		logic op;
		logic [15:0] a;
		logic [7:0] d;
		int sel;
		sel = $urandom_range(0, 99);
		op  = 1'($urandom_range(0, 1));
		a   = 16'($urandom_range(0, 16'hFFFF));
		d   = 8'($urandom_range(0, 255));
		if (sel < 15) begin
			op = OP_WRITE;
			a  = 16'($urandom_range(0, 16'h1FFF));
			if ($urandom_range(0, 3) != 0) d[3:0] = RAM_EN_KEY;
		end else if (sel < 30) begin
			op = OP_WRITE;
			a  = 16'($urandom_range(16'h2000, 16'h3FFF));
		end else if (sel < 40) begin
			op = OP_WRITE;
			a  = 16'($urandom_range(16'h4000, 16'h7FFF));
		end else if (sel < 60) begin
			op = OP_READ;
			a  = 16'($urandom_range(0, 16'h7FFF));
		end else if (sel < 88) begin
			a  = 16'($urandom_range(16'hA000, 16'hBFFF));
		end
		send(op, a, d);
	endtask

	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = hold_next ? LONG_HOLD : (burst ? 0 : $urandom_range(0, 13));
			hold_next = 1'b0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(negedge clk); while (!out_valid);
			sb.check_result(target, mem_address, ram_write_data, force_high_nibble);
			@(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [7:0] ptype [14];
		logic [7:0] psize [14];
		ptype = '{8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h10, 8'h11, 8'h12, 8'h13, 8'h19,
			8'h1B, 8'h1D, 8'h00, 8'h42};
		psize = '{8'h03, 8'h02, 8'h04, 8'h00, 8'h03, 8'h03, 8'h02, 8'h00, 8'h04, 8'h04,
			8'h03, 8'h02, 8'h00, 8'h01};
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		opcode      = OP_READ;
		bus_address = '0;
		write_value = '0;
		out_stall   = 1'b0;
		burst       = 1'b0;
		hold_next   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// ROM only
		configure(8'h00, 8'h00);
		send(OP_READ, 16'h0000, 8'h00);
		send(OP_READ, 16'hFFFF, 8'h00);
		send(OP_WRITE, 16'h1234, 8'h5A);

		// MBC1: bank zero seen as one, banked RAM, window edges, disable
		configure(8'h01, RAM_SIZE_32K);
		send(OP_WRITE, 16'h0000, 8'h0A);
		send(OP_READ, 16'h4000, 8'h00);
		send(OP_WRITE, 16'h2000, 8'hFF);
		send(OP_READ, 16'h7FFF, 8'h00);
		send(OP_WRITE, 16'h4000, 8'hFF);
		send(OP_WRITE, 16'hBFFF, 8'hFF);
		send(OP_READ, 16'hA000, 8'h00);
		send(OP_READ, 16'h9FFF, 8'h00);
		send(OP_READ, 16'hC000, 8'h00);
		send(OP_WRITE, 16'h0000, 8'h00);
		send(OP_READ, 16'hA000, 8'h00);

		// MBC2: address bit 8 picks bank or enable, 512-entry RAM wraps
		configure(8'h05, 8'h00);
		send(OP_WRITE, 16'h0000, 8'h0A);
		send(OP_WRITE, 16'h0100, 8'h0F);
		send(OP_READ, 16'h4000, 8'h00);
		send(OP_WRITE, 16'hA3FF, 8'hA5);
		send(OP_READ, 16'hB200, 8'h00);

		// MBC5: ninth bank bit, bank zero stays zero, 128KB RAM top
		configure(8'h1E, RAM_SIZE_128K);
		send(OP_WRITE, 16'h3000, 8'h01);
		send(OP_READ, 16'h4000, 8'h00);
		send(OP_WRITE, 16'h2000, 8'h00);
		send(OP_WRITE, 16'h3000, 8'h00);
		send(OP_READ, 16'h5000, 8'h00);
		send(OP_WRITE, 16'h4000, 8'hFF);
		send(OP_WRITE, 16'h0000, 8'h0A);
		send(OP_WRITE, 16'hBFFF, 8'h80);

		// unknown type
		configure(8'hFF, 8'hFF);
		send(OP_READ, 16'h0000, 8'h00);
		send(OP_WRITE, 16'hA000, 8'h0A);

		for (int p = 0; p < 14; p++) begin
			configure(ptype[p], psize[p]);
			if (p == 2) begin
				// back-pressure: output held off while requests keep coming
				burst     = 1'b1;
				hold_next = 1'b1;
				repeat (24) send_random();
			end
			for (int i = 0; i < 48; i++) begin
				if (i % 12 == 0) burst = ($urandom_range(0, 2) == 0);
				send_random();
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
